// ----- hdl/lmt_pkg.sv -----
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types and constants of the loop time monitor.
// ----------------------------------------------------------------------------
package lmt_pkg;

    // Event classes decided by the front end
    localparam logic [1:0] KIND_START   = 2'd0;  // start while idle
    localparam logic [1:0] KIND_OVERRUN = 2'd1;  // start while loop open
    localparam logic [1:0] KIND_END     = 2'd2;  // end of an open loop
    localparam logic [1:0] KIND_NOP     = 2'd3;  // end while idle

    // Configuration register indexes
    localparam logic CFG_ALPHA  = 1'b0;
    localparam logic CFG_WINDOW = 1'b1;

    // Reset values and fixed constants
    localparam logic [15:0] ALPHA_RESET  = 16'd66;
    localparam logic [31:0] WINDOW_RESET = 32'd1000000;
    localparam logic [14:0] PCT_FULL     = 15'd25600;

    // One classified event, front end to back end
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] elapsed;
        logic [63:0] stamp;
    } t_cmd;

endpackage

// ----- hdl/lmt_front.sv -----
// ----------------------------------------------------------------------------
// lmt_front
// Accepts events, tracks the open loop and classifies each beat.
// ----------------------------------------------------------------------------
module lmt_front import lmt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [63:0] i_timestamp_us,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic        r_loop_open;
    logic        n_loop_open;
    logic [63:0] r_start_stamp;
    logic [63:0] n_start_stamp;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Classify the beat and work out the next loop state
    always_comb begin
        n_loop_open     = r_loop_open;
        n_start_stamp   = r_start_stamp;
        o_cmd.stamp     = i_timestamp_us;
        o_cmd.elapsed   = i_timestamp_us[31:0] - r_start_stamp[31:0];
        if (!i_mode) begin
            if (r_loop_open) begin
                o_cmd.kind = KIND_OVERRUN;
            end else begin
                o_cmd.kind    = KIND_START;
                n_loop_open   = 1'b1;
                n_start_stamp = i_timestamp_us;
            end
        end else begin
            if (r_loop_open) begin
                o_cmd.kind  = KIND_END;
                n_loop_open = 1'b0;
            end else begin
                o_cmd.kind = KIND_NOP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_open   <= 1'b0;
            r_start_stamp <= '0;
        end else if (o_push) begin
            r_loop_open   <= n_loop_open;
            r_start_stamp <= n_start_stamp;
        end
    end

endmodule

// ----- hdl/lmt_fifo.sv -----
// ----------------------------------------------------------------------------
// lmt_fifo
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module lmt_fifo import lmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ----- hdl/lmt_back.sv -----
// ----------------------------------------------------------------------------
// lmt_back
// Statistics engine: counters, maxima, window, average and overrun share.
// ----------------------------------------------------------------------------
module lmt_back import lmt_pkg::*; #(
    parameter int COUNT_WIDTH = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_ema_alpha,
    input  logic [31:0] i_window_us,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_avg_loop_time,
    output logic [31:0] o_max_loop_last_window,
    output logic [31:0] o_max_loop_ever,
    output logic [14:0] o_overrun_percent,
    output logic [47:0] o_started_count,
    output logic [47:0] o_overrun_count
);

    localparam int NumW = COUNT_WIDTH + 15;
    localparam int ExtW = (COUNT_WIDTH > 48) ? COUNT_WIDTH : 48;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]             r_state;
    logic [1:0]             r_step;
    logic [3:0]             r_bit;
    logic [31:0]            r_elapsed;
    logic [47:0]            r_avg;
    logic [47:0]            r_acc;
    logic [48:0]            r_prod;
    logic [31:0]            r_win_run;
    logic [31:0]            r_win_latch;
    logic [31:0]            r_gmax;
    logic [63:0]            r_deadline;
    logic [COUNT_WIDTH-1:0] r_started;
    logic [COUNT_WIDTH-1:0] r_overrun;
    logic [NumW-1:0]        r_rem;
    logic [NumW-1:0]        r_dsh;
    logic [14:0]            r_q;
    logic                   r_out_valid;
    logic [47:0]            r_out_avg;
    logic [31:0]            r_out_wmax;
    logic [31:0]            r_out_gmax;
    logic [14:0]            r_out_pct;
    logic [47:0]            r_out_started;
    logic [47:0]            r_out_overrun;

    logic [16:0]            w_weight;
    logic [31:0]            mul_a;
    logic [16:0]            mul_b;
    logic [47:0]            addend;
    logic [31:0]            run_max;
    logic [COUNT_WIDTH:0]   total;
    logic [NumW-1:0]        num;
    logic [ExtW-1:0]        ext_started;
    logic [ExtW-1:0]        ext_overrun;
    logic                   out_load;

    assign w_weight = 17'h10000 - {1'b0, i_ema_alpha};
    assign o_pop    = (r_state == S_IDLE) && !i_empty;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // Shared multiplier operands: high part, new sample, low part
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = r_avg[47:16];
                mul_b = w_weight;
            end
            2'd1: begin
                mul_a = r_elapsed;
                mul_b = {1'b0, i_ema_alpha};
            end
            default: begin
                mul_a = {16'd0, r_avg[15:0]};
                mul_b = w_weight;
            end
        endcase
    end

    assign addend = (r_step == 2'd2) ? 48'(r_prod >> 16) : r_prod[47:0];

    // Running window maximum including the incoming loop
    assign run_max = (i_cmd.elapsed > r_win_run) ? i_cmd.elapsed : r_win_run;

    // Divider setup: overrun * 25600 over started + overrun
    assign total = {1'b0, r_started} + {1'b0, r_overrun};
    assign num   = (NumW'(r_overrun) << 14) + (NumW'(r_overrun) << 13)
                 + (NumW'(r_overrun) << 10);

    assign ext_started = ExtW'(r_started);
    assign ext_overrun = ExtW'(r_overrun);

    // Sequencer and statistics state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 2'd0;
            r_bit       <= 4'd0;
            r_avg       <= '0;
            r_win_run   <= '0;
            r_win_latch <= '0;
            r_gmax      <= '0;
            r_deadline  <= 64'(WINDOW_RESET);
            r_started   <= '0;
            r_overrun   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_elapsed <= i_cmd.elapsed;
                        r_acc     <= '0;
                        r_step    <= 2'd0;
                        r_state   <= S_PREP;
                        case (i_cmd.kind)
                            KIND_START: begin
                                if (r_started != '1) begin
                                    r_started <= r_started + 1'b1;
                                end
                            end
                            KIND_OVERRUN: begin
                                if (r_overrun != '1) begin
                                    r_overrun <= r_overrun + 1'b1;
                                end
                            end
                            KIND_END: begin
                                r_state <= S_MUL;
                                if (i_cmd.elapsed > r_gmax) begin
                                    r_gmax <= i_cmd.elapsed;
                                end
                                if (i_cmd.stamp > r_deadline) begin
                                    r_deadline  <= r_deadline + 64'(i_window_us);
                                    r_win_latch <= run_max;
                                    r_win_run   <= '0;
                                end else begin
                                    r_win_run <= run_max;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_step == 2'd2) begin
                        r_avg   <= r_acc + addend;
                        r_state <= S_PREP;
                    end else begin
                        r_acc   <= r_acc + addend;
                        r_step  <= r_step + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_PREP: begin
                    r_rem   <= num;
                    r_dsh   <= NumW'(total) << 14;
                    r_q     <= '0;
                    r_bit   <= 4'd14;
                    r_state <= (total == '0) ? S_OUT : S_DIV;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle
                    if (r_dsh <= r_rem) begin
                        r_rem        <= r_rem - r_dsh;
                        r_q[r_bit]   <= 1'b1;
                    end
                    r_dsh <= r_dsh >> 1;
                    r_bit <= r_bit - 4'd1;
                    if (r_bit == 4'd0) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register, parts the engine from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg     <= r_avg;
            r_out_wmax    <= r_win_latch;
            r_out_gmax    <= r_gmax;
            r_out_pct     <= r_q;
            r_out_started <= ext_started[47:0];
            r_out_overrun <= ext_overrun[47:0];
        end
    end

    assign o_valid                = r_out_valid;
    assign o_avg_loop_time        = r_out_avg;
    assign o_max_loop_last_window = r_out_wmax;
    assign o_max_loop_ever        = r_out_gmax;
    assign o_overrun_percent      = r_out_pct;
    assign o_started_count        = r_out_started;
    assign o_overrun_count        = r_out_overrun;

    // Overrun share never exceeds one hundred percent
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_q <= PCT_FULL))
        else $error("overrun share above full scale");

    // Average stays within the largest loop seen
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_avg[47:16] <= r_gmax)
        else $error("average above global maximum");

    // Latched window maximum is bounded by the global maximum
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win_latch <= r_gmax)
        else $error("window maximum above global maximum");

    // Queue is only drained while the engine is idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MUL || r_state == S_PREP))
        else $error("command popped outside idle");

endmodule

// ----- hdl/loop_time_monitor_unit.sv -----
// ----------------------------------------------------------------------------
// loop_time_monitor_unit
// Scheduler loop time monitor: average, maxima and overrun statistics.
//
//  Channel  Direction  Handshake            Beat
//  -------  ---------  -------------------  -------------------------------
//  event    in         i_valid / o_ready    i_mode, i_timestamp_us
//  stats    out        o_valid / i_ready    six statistics fields
//  config   in         i_cfg_we             i_cfg_addr, i_cfg_data
//
// In the engine, an end beat drives the shared 32x17 multiplier through three
// multiply/accumulate passes, and the overrun share of every beat comes from
// a 15-step restoring divider.
// A two-entry queue lets the front accept beats while the engine works; the
// stats register holds a finished beat while the engine continues.
// Reset is synchronous, active low, and clears all statistics.
// ----------------------------------------------------------------------------
module loop_time_monitor_unit import lmt_pkg::*; #(
    parameter int COUNT_WIDTH = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [63:0] i_timestamp_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [47:0] o_avg_loop_time,
    output logic [31:0] o_max_loop_last_window,
    output logic [31:0] o_max_loop_ever,
    output logic [14:0] o_overrun_percent,
    output logic [47:0] o_started_count,
    output logic [47:0] o_overrun_count,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    logic [15:0] r_ema_alpha;
    logic [31:0] r_window_us;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_cmd        push_cmd;
    t_cmd        pop_cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_alpha <= ALPHA_RESET;
            r_window_us <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ALPHA:  r_ema_alpha <= i_cfg_data[15:0];
                CFG_WINDOW: r_window_us <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lmt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_timestamp_us (i_timestamp_us),
        .i_full         (full),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    lmt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (pop_cmd)
    );

    lmt_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_ema_alpha            (r_ema_alpha),
        .i_window_us            (r_window_us),
        .i_empty                (empty),
        .i_cmd                  (pop_cmd),
        .o_pop                  (pop),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_avg_loop_time        (o_avg_loop_time),
        .o_max_loop_last_window (o_max_loop_last_window),
        .o_max_loop_ever        (o_max_loop_ever),
        .o_overrun_percent      (o_overrun_percent),
        .o_started_count        (o_started_count),
        .o_overrun_count        (o_overrun_count)
    );

endmodule
